FILE: rtl/core/rsap_pkg.sv
// shared types and constants for the radius sequence attribute parser
`default_nettype none
package rsap_pkg;

   localparam int MAX_PACKET_DEFAULT = 4096;

   localparam int HDR_LEN  = 20;
   localparam int AUTH_LEN = 16;
   localparam int MIN_WALK = 4;
   localparam int SEQ_LEN  = 4;

   localparam logic [7:0] VSA_TYPE    = 8'd26;
   localparam logic [7:0] SEQ_SUBTYPE = 8'd201;

   // status codes of a result
   localparam logic [2:0] ST_SEQ_FOUND = 3'd0;
   localparam logic [2:0] ST_OK_NO_SEQ = 3'd1;
   localparam logic [2:0] ST_LEN_ERR   = 3'd2;
   localparam logic [2:0] ST_FRAME_ERR = 3'd3;
   localparam logic [2:0] ST_SEQ_LEN   = 3'd4;

   // walk error code, no error shares the zero code
   localparam logic [2:0] ERR_NONE = 3'd0;

   typedef enum logic [7:0] {
      PH_HDR   = 8'b0000_0001,
      PH_TYPE  = 8'b0000_0010,
      PH_LEN   = 8'b0000_0100,
      PH_VEND  = 8'b0000_1000,
      PH_VTYPE = 8'b0001_0000,
      PH_VLEN  = 8'b0010_0000,
      PH_BODY  = 8'b0100_0000,
      PH_DONE  = 8'b1000_0000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  packet_code;
      logic [7:0]  packet_id;
      logic [31:0] sequence_number;
      logic [63:0] auth_high;
      logic [63:0] auth_low;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/rsap_parser.sv
// per-byte packet walk: header capture, attribute framing and status on the last byte
`default_nettype none
module rsap_parser #(
   parameter int MAX_PACKET = rsap_pkg::MAX_PACKET_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             enable,
   input  wire rsap_pkg::req_type req_item,
   output logic                  done,
   output rsap_pkg::rsp_type     result
);

   localparam int CW   = $clog2(MAX_PACKET + 2);
   localparam int AW   = $clog2(MAX_PACKET + 262);
   localparam int WW   = ((AW > 16) ? AW : 16) + 1;
   localparam logic [CW-1:0] MAX_C = CW'(MAX_PACKET);

   logic [CW-1:0]       byte_count_ff, byte_count_in;
   logic [15:0]         declared_length_ff, declared_length_in;
   logic [AW-1:0]       attr_start_ff, attr_start_in;
   logic [AW-1:0]       attr_end_ff, attr_end_in;
   rsap_pkg::phase_type attr_phase_ff, attr_phase_in;
   logic [7:0]          attr_type_ff, attr_type_in;
   logic [7:0]          sub_type_ff, sub_type_in;
   logic [31:0]         seq_value_ff, seq_value_in;
   logic                seq_done_ff, seq_done_in;
   logic [2:0]          err_code_ff, err_code_in;
   logic [7:0]          code_ff, code_in;
   logic [7:0]          id_ff, id_in;
   logic [63:0]         auth_hi_ff, auth_hi_in;
   logic [63:0]         auth_lo_ff, auth_lo_in;

   logic [7:0]    c;
   logic [WW-1:0] pos_w, dl_w, na_pos;
   logic          do_next;
   logic          seq_attr;
   logic [AW-1:0] end_calc;
   logic [2:0]    status;

   assign c     = req_item.data_byte;
   assign pos_w = WW'(byte_count_ff);
   assign dl_w  = WW'(declared_length_ff);

   always_comb begin
      byte_count_in      = byte_count_ff;
      declared_length_in = declared_length_ff;
      attr_start_in      = attr_start_ff;
      attr_end_in        = attr_end_ff;
      attr_phase_in      = attr_phase_ff;
      attr_type_in       = attr_type_ff;
      sub_type_in        = sub_type_ff;
      seq_value_in       = seq_value_ff;
      seq_done_in        = seq_done_ff;
      err_code_in        = err_code_ff;
      code_in            = code_ff;
      id_in              = id_ff;
      auth_hi_in         = auth_hi_ff;
      auth_lo_in         = auth_lo_ff;
      do_next            = 1'b0;
      na_pos             = '0;
      end_calc           = '0;
      seq_attr = (attr_type_ff == rsap_pkg::VSA_TYPE) && (sub_type_ff == rsap_pkg::SEQ_SUBTYPE);
      status             = rsap_pkg::ST_LEN_ERR;

      if (enable) begin
         if (byte_count_ff >= MAX_C) begin
            byte_count_in = MAX_C + CW'(1);
         end else begin
            byte_count_in = byte_count_ff + CW'(1);
            case (attr_phase_ff)
               rsap_pkg::PH_HDR: begin
                  if (pos_w == WW'(0)) begin
                     code_in = c;
                  end else if (pos_w == WW'(1)) begin
                     id_in = c;
                  end else if (pos_w < WW'(4)) begin
                     declared_length_in = {declared_length_ff[7:0], c};
                  end else if (pos_w < WW'(12)) begin
                     auth_hi_in = {auth_hi_ff[55:0], c};
                  end else if (pos_w < WW'(4 + rsap_pkg::AUTH_LEN)) begin
                     auth_lo_in = {auth_lo_ff[55:0], c};
                  end
                  if (pos_w == WW'(rsap_pkg::HDR_LEN - 1)) begin
                     do_next = 1'b1;
                     na_pos  = WW'(rsap_pkg::HDR_LEN);
                  end
               end
               rsap_pkg::PH_TYPE: begin
                  attr_type_in  = c;
                  sub_type_in   = '0;
                  attr_phase_in = rsap_pkg::PH_LEN;
               end
               rsap_pkg::PH_LEN: begin
                  if (c < 8'd2) begin
                     attr_phase_in = rsap_pkg::PH_DONE;
                     err_code_in   = rsap_pkg::ST_FRAME_ERR;
                  end else if (attr_type_ff == rsap_pkg::VSA_TYPE) begin
                     attr_phase_in = rsap_pkg::PH_VEND;
                  end else begin
                     end_calc    = attr_start_ff + AW'(c);
                     attr_end_in = end_calc;
                     if (pos_w + WW'(1) == WW'(end_calc)) begin
                        do_next = 1'b1;
                        na_pos  = WW'(end_calc);
                     end else begin
                        attr_phase_in = rsap_pkg::PH_BODY;
                     end
                  end
               end
               rsap_pkg::PH_VEND: begin
                  // vendor id bytes are skipped
                  if (pos_w == WW'(attr_start_ff) + WW'(5)) begin
                     attr_phase_in = rsap_pkg::PH_VTYPE;
                  end
               end
               rsap_pkg::PH_VTYPE: begin
                  sub_type_in   = c;
                  attr_phase_in = rsap_pkg::PH_VLEN;
               end
               rsap_pkg::PH_VLEN: begin
                  if (c < 8'd2) begin
                     attr_phase_in = rsap_pkg::PH_DONE;
                     err_code_in   = rsap_pkg::ST_FRAME_ERR;
                  end else if (sub_type_ff == rsap_pkg::SEQ_SUBTYPE &&
                               c != 8'(rsap_pkg::SEQ_LEN + 2)) begin
                     attr_phase_in = rsap_pkg::PH_DONE;
                     err_code_in   = rsap_pkg::ST_SEQ_LEN;
                  end else begin
                     end_calc    = attr_start_ff + AW'(6) + AW'(c);
                     attr_end_in = end_calc;
                     if (pos_w + WW'(1) == WW'(end_calc)) begin
                        do_next = 1'b1;
                        na_pos  = WW'(end_calc);
                     end else begin
                        attr_phase_in = rsap_pkg::PH_BODY;
                     end
                  end
               end
               rsap_pkg::PH_BODY: begin
                  if (seq_attr) begin
                     seq_value_in = {seq_value_ff[23:0], c};
                  end
                  if (pos_w + WW'(1) == WW'(attr_end_ff)) begin
                     if (seq_attr) begin
                        seq_done_in   = 1'b1;
                        attr_phase_in = rsap_pkg::PH_DONE;
                     end else begin
                        do_next = 1'b1;
                        na_pos  = WW'(attr_end_ff);
                     end
                  end
               end
               default: begin
               end
            endcase

            // decide what follows an attribute boundary
            if (do_next) begin
               if (na_pos == dl_w) begin
                  attr_phase_in = rsap_pkg::PH_DONE;
                  err_code_in   = rsap_pkg::ERR_NONE;
               end else if (na_pos > dl_w || dl_w - na_pos <= WW'(rsap_pkg::MIN_WALK)) begin
                  attr_phase_in = rsap_pkg::PH_DONE;
                  err_code_in   = rsap_pkg::ST_FRAME_ERR;
               end else begin
                  attr_start_in = AW'(na_pos);
                  attr_phase_in = rsap_pkg::PH_TYPE;
               end
            end
         end

         if (byte_count_in > MAX_C || byte_count_in < CW'(rsap_pkg::HDR_LEN) ||
             WW'(byte_count_in) != WW'(declared_length_in)) begin
            status = rsap_pkg::ST_LEN_ERR;
         end else if (seq_done_in) begin
            status = rsap_pkg::ST_SEQ_FOUND;
         end else if (attr_phase_in == rsap_pkg::PH_DONE) begin
            status = (err_code_in == rsap_pkg::ERR_NONE) ? rsap_pkg::ST_OK_NO_SEQ
                                                         : err_code_in;
         end else begin
            status = rsap_pkg::ST_FRAME_ERR;
         end
      end
   end

   assign done                   = enable & req_item.last_byte;
   assign result.status          = status;
   assign result.packet_code     = code_in;
   assign result.packet_id       = id_in;
   assign result.sequence_number = (status == rsap_pkg::ST_SEQ_FOUND) ? seq_value_in : 32'd0;
   assign result.auth_high       = auth_hi_in;
   assign result.auth_low        = auth_lo_in;

   always_ff @(posedge clock) begin
      if (reset || done) begin
         // the last byte returns the walk to its start for the next packet
         byte_count_ff      <= '0;
         declared_length_ff <= '0;
         attr_start_ff      <= AW'(rsap_pkg::HDR_LEN);
         attr_end_ff        <= '0;
         attr_phase_ff      <= rsap_pkg::PH_HDR;
         attr_type_ff       <= '0;
         sub_type_ff        <= '0;
         seq_value_ff       <= '0;
         seq_done_ff        <= 1'b0;
         err_code_ff        <= rsap_pkg::ERR_NONE;
         code_ff            <= '0;
         id_ff              <= '0;
         auth_hi_ff         <= '0;
         auth_lo_ff         <= '0;
      end else begin
         byte_count_ff      <= byte_count_in;
         declared_length_ff <= declared_length_in;
         attr_start_ff      <= attr_start_in;
         attr_end_ff        <= attr_end_in;
         attr_phase_ff      <= attr_phase_in;
         attr_type_ff       <= attr_type_in;
         sub_type_ff        <= sub_type_in;
         seq_value_ff       <= seq_value_in;
         seq_done_ff        <= seq_done_in;
         err_code_ff        <= err_code_in;
         code_ff            <= code_in;
         id_ff              <= id_in;
         auth_hi_ff         <= auth_hi_in;
         auth_lo_ff         <= auth_lo_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/radius_sequence_attribute_parser.sv
// top level: request handshake, packet walk and registered result
`default_nettype none
// Parses a RADIUS packet at one byte per clock while req_ready is high. Each
// request carries one packet byte in wire order. The request flagged last_byte
// closes the packet: the edge that accepts it loads one result into the result
// register, so rsp_valid rises in the cycle after that request. The result holds
// the status, the header code and identifier, the authenticator and the sequence
// number of the first four-byte vendor sub-attribute 201. Bytes that are not last
// produce no result. A request is accepted when req_valid and req_ready are
// high; req_ready drops only while a result sits in the register and rsp_ready
// is low. Bytes beyond MAX_PACKET are not parsed and give a length mismatch.
module radius_sequence_attribute_parser #(
   parameter int MAX_PACKET = rsap_pkg::MAX_PACKET_DEFAULT
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rsap_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsap_pkg::rsp_type      rsp_payload
);

   logic              accept;
   logic              done;
   rsap_pkg::rsp_type result;
   logic              rsp_valid_ff, rsp_valid_in;
   rsap_pkg::rsp_type rsp_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   rsap_parser #(
      .MAX_PACKET (MAX_PACKET)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .enable   (accept),
      .req_item (req_payload),
      .done     (done),
      .result   (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (done) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule
`default_nettype wire
